/* rtl/lzwe_pkg.sv */
// ----------------------------------------------------------------------------
// LZW byte encoder package
// Shared widths, constants and the dictionary write beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package lzwe_pkg;

  // dictionary and alphabet sizes
  localparam int DICT_ENTRIES = 65536;
  localparam int ROOT_SYMBOLS = 256;
  localparam int CODE_W       = $clog2(DICT_ENTRIES);
  localparam int NF_W         = CODE_W + 1;
  localparam int BYTE_W       = 8;

  // hash table of chain heads
  localparam int HASH_W       = 16;
  localparam logic [HASH_W-1:0] HASH_MULT = HASH_W'(16'h009D);

  // code width limits
  localparam int WIDTH_W      = 5;
  localparam logic [WIDTH_W-1:0] START_WIDTH = WIDTH_W'(9);
  localparam logic [WIDTH_W-1:0] MAX_WIDTH   = WIDTH_W'(16);

  // one dictionary insert: entry at code, chain link, and new head for slot
  typedef struct packed {
    logic              en;
    logic [CODE_W-1:0] code;
    logic [HASH_W-1:0] slot;
    logic [CODE_W-1:0] prefix;
    logic [BYTE_W-1:0] suffix;
    logic [CODE_W-1:0] link;
  } dict_wr_t;

endpackage

`default_nettype wire

/* rtl/lzw_byte_encoder_top.sv */
// ----------------------------------------------------------------------------
// LZW byte encoder, variable code width
// Hashed-chain dictionary lookup under a small sequencer; emits miss codes and
// the flushed final code of each stream.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat content
//  --------+-----+--------------------------------------------------------
//  in_     | in  | tdata[7:0] data_byte, tlast end_of_input
//  out_    | out | tdata[15:0] code, [20:16] code_bits; tlast final_code
//
//  The first byte of a stream is only accepted. A later byte runs accept, head
//  read, entry read and compare to a hit on the first chain entry, plus an entry
//  read and compare per further entry walked. A miss ends in one insert-and-emit
//  state, and the final flush adds a flush state. The single read port of each
//  memory sets this sequence.
//  No clearing pass after reset or between streams: stale heads and links are
//  filtered by code range and a hash re-check.
//  A full output register stalls the sequencer in its emit states only.
//
`default_nettype none

module lzw_byte_encoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // end_of_input
  // code stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [15:0] code, [20:16] code_bits, zero pad
  output logic             out_tlast   // final_code
);

  localparam int CW = lzwe_pkg::CODE_W;
  localparam int NW = lzwe_pkg::NF_W;
  localparam int BW = lzwe_pkg::BYTE_W;
  localparam int HW = lzwe_pkg::HASH_W;
  localparam int WW = lzwe_pkg::WIDTH_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HEAD = 3'd1;
  localparam logic [2:0] ST_NODE = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_MISS = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam logic [CW-1:0] ROOT_CODE = CW'(lzwe_pkg::ROOT_SYMBOLS);
  localparam logic [NW-1:0] ROOT_NF   = NW'(lzwe_pkg::ROOT_SYMBOLS);
  localparam logic [NW-1:0] DICT_NF   = NW'(lzwe_pkg::DICT_ENTRIES);
  localparam logic [BW-1:0] TOP_SYM   = BW'(lzwe_pkg::ROOT_SYMBOLS - 1);

  logic [2:0]    state_r,   state_nxt;
  logic          pvalid_r,  pvalid_nxt;
  logic [CW-1:0] prefix_r,  prefix_nxt;
  logic [NW-1:0] nf_r,      nf_nxt;
  logic [WW-1:0] width_r,   width_nxt;
  logic [BW-1:0] byte_r,    byte_nxt;
  logic          last_r,    last_nxt;
  logic          first_r,   first_nxt;
  logic [CW-1:0] cand_r,    cand_nxt;
  logic [NW-1:0] bound_r,   bound_nxt;
  logic [CW-1:0] head_r,    head_nxt;
  logic [HW-1:0] slot_r,    slot_nxt;
  logic          ovalid_r,  ovalid_nxt;
  logic [CW-1:0] ocode_r,   ocode_nxt;
  logic [WW-1:0] obits_r,   obits_nxt;
  logic          ofinal_r,  ofinal_nxt;

  logic [CW-1:0] head_rdata;
  logic [CW-1:0] ent_prefix;
  logic [BW-1:0] ent_suffix;
  logic [CW-1:0] ent_link;
  logic          head_rd_en;
  logic          ent_rd_en;
  logic [CW-1:0] cand_sel;
  logic [NW-1:0] bound_sel;
  logic          cand_ok;
  logic [CW-1:0] hash_prefix;
  logic [BW-1:0] hash_sym;
  logic [HW-1:0] hash_slot;
  logic          out_free;
  logic [BW-1:0] in_sym;
  logic [NW-1:0] nf_inc;
  logic [NW-1:0] width_lim;
  lzwe_pkg::dict_wr_t wr;

  // shared hash unit: lookup key in HEAD, probed entry in CMP
  assign hash_prefix = (state_r == ST_HEAD) ? prefix_r : ent_prefix;
  assign hash_sym    = (state_r == ST_HEAD) ? byte_r   : ent_suffix;

  lzwe_hash u_hash (
    .prefix (hash_prefix),
    .sym    (hash_sym),
    .slot   (hash_slot)
  );

  lzwe_dict u_dict (
    .clk        (clk),
    .head_rd_en (head_rd_en),
    .head_raddr (hash_slot),
    .head_rdata (head_rdata),
    .ent_rd_en  (ent_rd_en),
    .ent_raddr  (cand_sel),
    .ent_prefix (ent_prefix),
    .ent_suffix (ent_suffix),
    .ent_link   (ent_link),
    .wr         (wr)
  );

  // input byte saturated to the alphabet
  assign in_sym = ({1'b0, in_tdata} >= (BW+1)'(lzwe_pkg::ROOT_SYMBOLS)) ? TOP_SYM : in_tdata;

  // chain candidate: head on the first probe, link afterwards
  assign cand_sel  = first_r ? head_rdata : cand_r;
  assign bound_sel = first_r ? nf_r : bound_r;
  assign cand_ok   = (cand_sel >= ROOT_CODE) && ({1'b0, cand_sel} < bound_sel);

  // next-free and width after an insert
  assign nf_inc    = (nf_r < DICT_NF) ? (nf_r + NW'(1)) : nf_r;
  assign width_lim = (NW'(1) << width_r) - NW'(1);

  assign out_free  = !ovalid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    pvalid_nxt = pvalid_r;
    prefix_nxt = prefix_r;
    nf_nxt     = nf_r;
    width_nxt  = width_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    first_nxt  = first_r;
    cand_nxt   = cand_r;
    bound_nxt  = bound_r;
    head_nxt   = head_r;
    slot_nxt   = slot_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ocode_nxt  = ocode_r;
    obits_nxt  = obits_r;
    ofinal_nxt = ofinal_r;
    head_rd_en = 1'b0;
    ent_rd_en  = 1'b0;
    wr         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          byte_nxt = in_sym;
          last_nxt = in_tlast;
          if (!pvalid_r) begin
            prefix_nxt = CW'(in_sym);
            pvalid_nxt = 1'b1;
            state_nxt  = in_tlast ? ST_FIN : ST_IDLE;
          end else begin
            state_nxt  = ST_HEAD;
          end
        end
      end

      // read the chain head for (prefix, byte)
      ST_HEAD: begin
        head_rd_en = 1'b1;
        slot_nxt   = hash_slot;
        first_nxt  = 1'b1;
        state_nxt  = ST_NODE;
      end

      // range-check the candidate and read its entry
      ST_NODE: begin
        if (first_r) begin
          head_nxt = head_rdata;
        end
        if (cand_ok) begin
          ent_rd_en = 1'b1;
          cand_nxt  = cand_sel;
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_MISS;
        end
        first_nxt = 1'b0;
      end

      // compare entry; follow the link only while it stays in this slot
      ST_CMP: begin
        if (hash_slot == slot_r && ent_prefix == prefix_r && ent_suffix == byte_r) begin
          prefix_nxt = cand_r;
          state_nxt  = last_r ? ST_FIN : ST_IDLE;
        end else if (hash_slot == slot_r) begin
          cand_nxt  = ent_link;
          bound_nxt = {1'b0, cand_r};
          state_nxt = ST_NODE;
        end else begin
          state_nxt = ST_MISS;
        end
      end

      // insert, emit the prefix code, restart the prefix from the byte
      ST_MISS: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ocode_nxt  = prefix_r;
          obits_nxt  = width_r;
          ofinal_nxt = 1'b0;
          wr.en      = (nf_r < DICT_NF);
          wr.code    = nf_r[CW-1:0];
          wr.slot    = slot_r;
          wr.prefix  = prefix_r;
          wr.suffix  = byte_r;
          wr.link    = head_r;
          nf_nxt     = nf_inc;
          prefix_nxt = CW'(byte_r);
          if (width_r < lzwe_pkg::MAX_WIDTH && nf_inc >= width_lim) begin
            width_nxt = width_r + WW'(1);
          end
          state_nxt  = last_r ? ST_FIN : ST_IDLE;
        end
      end

      // flush the final prefix and return to the stream start state
      ST_FIN: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          ocode_nxt  = prefix_r;
          obits_nxt  = width_r;
          ofinal_nxt = 1'b1;
          nf_nxt     = ROOT_NF;
          width_nxt  = lzwe_pkg::START_WIDTH;
          prefix_nxt = '0;
          pvalid_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pvalid_r <= 1'b0;
      prefix_r <= '0;
      nf_r     <= ROOT_NF;
      width_r  <= lzwe_pkg::START_WIDTH;
      first_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pvalid_r <= pvalid_nxt;
      prefix_r <= prefix_nxt;
      nf_r     <= nf_nxt;
      width_r  <= width_nxt;
      first_r  <= first_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // working and output payload
  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    last_r   <= last_nxt;
    cand_r   <= cand_nxt;
    bound_r  <= bound_nxt;
    head_r   <= head_nxt;
    slot_r   <= slot_nxt;
    ocode_r  <= ocode_nxt;
    obits_r  <= obits_nxt;
    ofinal_r <= ofinal_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {3'b000, obits_r, ocode_r};
  assign out_tlast  = ofinal_r;

endmodule

`default_nettype wire

/* rtl/lzwe_hash.sv */
// ----------------------------------------------------------------------------
// LZW hash unit
// Folds a (prefix, byte) pair into a chain-head slot index. Shared between
// the lookup and the chain-entry check.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwe_hash (
  input  wire logic [lzwe_pkg::CODE_W-1:0] prefix,
  input  wire logic [lzwe_pkg::BYTE_W-1:0] sym,
  output logic      [lzwe_pkg::HASH_W-1:0] slot
);

  logic [lzwe_pkg::HASH_W-1:0] sym_wide;
  logic [lzwe_pkg::HASH_W-1:0] sym_shift;
  logic [lzwe_pkg::HASH_W-1:0] sym_mult;
  logic [lzwe_pkg::HASH_W-1:0] prefix_wide;

  // prefix ^ (byte << 8) ^ (byte * 0x9D), kept to the slot width
  assign sym_wide    = lzwe_pkg::HASH_W'(sym);
  assign sym_shift   = sym_wide << 8;
  assign sym_mult    = sym_wide * lzwe_pkg::HASH_MULT;
  assign prefix_wide = lzwe_pkg::HASH_W'(prefix);
  assign slot        = prefix_wide ^ sym_shift ^ sym_mult;

endmodule

`default_nettype wire

/* rtl/lzwe_dict.sv */
// ----------------------------------------------------------------------------
// LZW dictionary memories
// Entry store (prefix, suffix, chain link) indexed by code, and chain-head
// table indexed by hash slot. One write and one registered read per memory.
// ----------------------------------------------------------------------------
`default_nettype none

module lzwe_dict (
  input  wire logic                          clk,
  // chain-head read
  input  wire logic                          head_rd_en,
  input  wire logic [lzwe_pkg::HASH_W-1:0]   head_raddr,
  output logic      [lzwe_pkg::CODE_W-1:0]   head_rdata,
  // entry read
  input  wire logic                          ent_rd_en,
  input  wire logic [lzwe_pkg::CODE_W-1:0]   ent_raddr,
  output logic      [lzwe_pkg::CODE_W-1:0]   ent_prefix,
  output logic      [lzwe_pkg::BYTE_W-1:0]   ent_suffix,
  output logic      [lzwe_pkg::CODE_W-1:0]   ent_link,
  // insert
  input  wire lzwe_pkg::dict_wr_t            wr
);

  localparam int HEAD_DEPTH = 2 ** lzwe_pkg::HASH_W;

  logic [lzwe_pkg::CODE_W-1:0] head_mem   [HEAD_DEPTH];
  logic [lzwe_pkg::CODE_W-1:0] prefix_mem [lzwe_pkg::DICT_ENTRIES];
  logic [lzwe_pkg::BYTE_W-1:0] suffix_mem [lzwe_pkg::DICT_ENTRIES];
  logic [lzwe_pkg::CODE_W-1:0] link_mem   [lzwe_pkg::DICT_ENTRIES];

  // chain heads
  always_ff @(posedge clk) begin
    if (wr.en) begin
      head_mem[wr.slot] <= wr.code;
    end
    if (head_rd_en) begin
      head_rdata <= head_mem[head_raddr];
    end
  end

  // entries
  always_ff @(posedge clk) begin
    if (wr.en) begin
      prefix_mem[wr.code] <= wr.prefix;
      suffix_mem[wr.code] <= wr.suffix;
      link_mem[wr.code]   <= wr.link;
    end
    if (ent_rd_en) begin
      ent_prefix <= prefix_mem[ent_raddr];
      ent_suffix <= suffix_mem[ent_raddr];
      ent_link   <= link_mem[ent_raddr];
    end
  end

endmodule

`default_nettype wire
